// ===== design/cdeq_pkg.sv =====
package cdeq_pkg;

  // Store geometry and value width
  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Back-pop selection tree: groups of cells, then one pass over the groups
  localparam int GROUP = (DEPTH < 32) ? DEPTH : 32;
  localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;

  // Operation codes
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_POP_FRONT  = 2'd1;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  typedef logic [VALUE_WIDTH-1:0] val_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic signed [31:0]  value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0]  popped;
    logic                was_empty;
    logic                push_dropped;
    logic                mismatch;
    logic                failed;
    logic [10:0]         occupancy;
  } out_res_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              shift_in;    // push front: every cell takes its left neighbor
    logic              shift_out;   // pop front: every cell takes its right neighbor
    logic              write_back;  // push back: the cell at the fill count takes value
    logic [CNT_W-1:0]  count;
    val_t              value;
  } cell_ctrl_t;

endpackage

// ===== design/checked_double_ended_queue_top.sv =====
// Checked double-ended queue. Each request names push front, pop front, push
// back or pop back and carries a value: the item to push, or what the pop is
// expected to return. Every request yields exactly one result. A pop on an
// empty queue returns -1, a push on a full queue is dropped and flagged, and
// the first pop that differs from its expected value sets a sticky failure
// after which the queue is frozen and later requests only report the frozen
// state. Items live in a row of cells with the front item in cell 0: a front
// push or pop shifts the whole row by one cell, a back push loads the cell at
// the fill count. A request is taken into a holding register and, when the
// result register is free, push front, pop front, push back and every request
// after a failure complete straight from it, so these sustain one request per
// cycle. A pop back on a non-empty queue passes through the group and select
// states: the back item is gathered from the cells through a two-level registered
// selection tree. No clearing pass is needed after reset.
module checked_double_ended_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdeq_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output cdeq_pkg::out_res_t out_res
);

  localparam int VW = cdeq_pkg::VALUE_WIDTH;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_GRP = 2'd1;
  localparam logic [1:0] ST_SEL = 2'd2;

  // Low 32 bits of a stored value, zero-extended when narrower
  function automatic logic [31:0] to_out(input cdeq_pkg::val_t v);
    logic [63:0] t;
    t = 64'(v);
    return t[31:0];
  endfunction

  logic                        hold_valid_r;
  cdeq_pkg::in_req_t           hold_r;
  logic                        out_valid_r;
  cdeq_pkg::out_res_t          out_r;
  cdeq_pkg::out_res_t          res;
  logic [1:0]                  state_r;
  logic [1:0]                  state_nxt;
  logic [cdeq_pkg::CNT_W-1:0]  count_r;
  logic [cdeq_pkg::CNT_W-1:0]  count_nxt;
  logic                        fail_r;
  logic                        fail_nxt;
  logic                        out_free;
  logic                        done;
  logic signed [63:0]          v64;
  cdeq_pkg::val_t              val_ext;
  cdeq_pkg::val_t              got;
  cdeq_pkg::val_t              back_sel;
  cdeq_pkg::cell_ctrl_t        ctrl;
  logic [cdeq_pkg::DEPTH-1:0][VW-1:0] cell_data;
  logic [cdeq_pkg::DEPTH-1:0][VW-1:0] cell_tag;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !hold_valid_r || done;
  assign out_valid = out_valid_r;
  assign out_res = out_r;

  assign v64 = 64'(hold_r.value);
  assign val_ext = v64[VW-1:0];

  // Sequence one request: decide the cell moves, the counters and the result
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    fail_nxt   = fail_r;
    done       = 1'b0;
    got        = '0;
    ctrl.shift_in   = 1'b0;
    ctrl.shift_out  = 1'b0;
    ctrl.write_back = 1'b0;
    ctrl.count      = count_r;
    ctrl.value      = val_ext;
    res.popped       = '0;
    res.was_empty    = 1'b0;
    res.push_dropped = 1'b0;
    res.mismatch     = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (hold_valid_r && out_free) begin
          if (fail_r) begin
            done = 1'b0 | 1'b1;
          end else if (hold_r.operation == cdeq_pkg::OP_PUSH_FRONT ||
                       hold_r.operation == cdeq_pkg::OP_PUSH_BACK) begin
            done = 1'b1;
            if (count_r == cdeq_pkg::CNT_W'(cdeq_pkg::DEPTH)) begin
              res.push_dropped = 1'b1;
            end else begin
              ctrl.shift_in   = (hold_r.operation == cdeq_pkg::OP_PUSH_FRONT);
              ctrl.write_back = (hold_r.operation == cdeq_pkg::OP_PUSH_BACK);
              count_nxt = count_r + cdeq_pkg::CNT_W'(1);
            end
          end else if (count_r == '0) begin
            done = 1'b1;
            got = '1;
            res.was_empty = 1'b1;
            res.popped = to_out(got);
            res.mismatch = (got != val_ext);
          end else if (hold_r.operation == cdeq_pkg::OP_POP_FRONT) begin
            done = 1'b1;
            got = cell_data[0];
            ctrl.shift_out = 1'b1;
            count_nxt = count_r - cdeq_pkg::CNT_W'(1);
            res.popped = to_out(got);
            res.mismatch = (got != val_ext);
          end else begin
            // pop back: wait for the selection tree
            state_nxt = ST_GRP;
          end
        end
      end
      ST_GRP: begin
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        done = 1'b1;
        state_nxt = ST_RUN;
        got = back_sel;
        count_nxt = count_r - cdeq_pkg::CNT_W'(1);
        res.popped = to_out(got);
        res.mismatch = (got != val_ext);
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
    if (res.mismatch) begin
      fail_nxt = 1'b1;
    end
    res.failed    = fail_nxt;
    res.occupancy = 11'(count_nxt);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      count_r      <= '0;
      fail_r       <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      fail_r  <= fail_nxt;
      if (in_valid && in_ready) begin
        hold_valid_r <= 1'b1;
      end else if (done) begin
        hold_valid_r <= 1'b0;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= in_req;
    end
    if (done) begin
      out_r <= res;
    end
  end

  // Row of cells, front item in cell 0
  for (genvar i = 0; i < cdeq_pkg::DEPTH; i++) begin : g_cell
    cdeq_pkg::val_t left_d;
    cdeq_pkg::val_t right_d;
    if (i == 0) begin : g_first
      assign left_d = val_ext;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == cdeq_pkg::DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    cdeq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .idx        (cdeq_pkg::IDX_W'(i)),
      .data       (cell_data[i]),
      .back_cand  (cell_tag[i])
    );
  end

  cdeq_backsel u_backsel (
    .clk  (clk),
    .cand (cell_tag),
    .sel  (back_sel)
  );

endmodule

// ===== design/cdeq_cell.sv =====
module cdeq_cell (
  input  logic                      clk,
  input  cdeq_pkg::cell_ctrl_t      ctrl,
  input  cdeq_pkg::val_t            left_data,
  input  cdeq_pkg::val_t            right_data,
  input  logic [cdeq_pkg::IDX_W-1:0] idx,
  output cdeq_pkg::val_t            data,
  output cdeq_pkg::val_t            back_cand
);

  cdeq_pkg::val_t                data_r;
  cdeq_pkg::val_t                data_nxt;
  logic [cdeq_pkg::CNT_W-1:0]    pos;

  assign pos = cdeq_pkg::CNT_W'(idx);

  // Shift toward the back, shift toward the front, or load at the back end
  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_in) begin
      data_nxt = left_data;
    end else if (ctrl.shift_out) begin
      data_nxt = right_data;
    end else if (ctrl.write_back && (pos == ctrl.count)) begin
      data_nxt = ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

  // Offer the content to the selection tree only when this cell holds the back item
  assign back_cand = (pos == (ctrl.count - cdeq_pkg::CNT_W'(1))) ? data_r : '0;

endmodule

// ===== design/cdeq_backsel.sv =====
module cdeq_backsel (
  input  logic                                          clk,
  input  logic [cdeq_pkg::DEPTH-1:0][cdeq_pkg::VALUE_WIDTH-1:0] cand,
  output cdeq_pkg::val_t                                sel
);

  logic [cdeq_pkg::NGRP-1:0][cdeq_pkg::VALUE_WIDTH-1:0] grp_r;
  logic [cdeq_pkg::NGRP-1:0][cdeq_pkg::VALUE_WIDTH-1:0] grp_nxt;
  cdeq_pkg::val_t                                       sel_r;
  cdeq_pkg::val_t                                       sel_nxt;

  // First level: merge the candidate cells of each group (at most one is nonzero)
  always_comb begin
    grp_nxt = '0;
    for (int g = 0; g < cdeq_pkg::NGRP; g++) begin
      for (int k = 0; k < cdeq_pkg::GROUP; k++) begin
        if (g * cdeq_pkg::GROUP + k < cdeq_pkg::DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | cand[g * cdeq_pkg::GROUP + k];
        end
      end
    end
  end

  // Second level: merge the group results
  always_comb begin
    sel_nxt = '0;
    for (int g = 0; g < cdeq_pkg::NGRP; g++) begin
      sel_nxt = sel_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    sel_r <= sel_nxt;
  end

  assign sel = sel_r;

endmodule
